@@ hdl/aat_pkg.sv @@
// Shared constants for the box affine transform pipeline.
package aat_pkg;

    // Default widths of a coordinate and of one matrix coefficient
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 20;

    // Fixed-point layout
    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int BIAS_W    = 16;

    // Reset values
    localparam logic [FRAC_BITS:0]  ONE_Q16    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [BIAS_W-1:0]   BIAS_RESET = BIAS_W'(655);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 3'd6;

endpackage

@@ hdl/aat_if.sv @@
// Valid/ready channels for local boxes and world boxes.
interface aat_box_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] lo_x;
    logic signed [COORD_WIDTH-1:0] lo_y;
    logic signed [COORD_WIDTH-1:0] lo_z;
    logic signed [COORD_WIDTH-1:0] hi_x;
    logic signed [COORD_WIDTH-1:0] hi_y;
    logic signed [COORD_WIDTH-1:0] hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aat_world_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] world_lo_x;
    logic signed [COORD_WIDTH-1:0] world_lo_y;
    logic signed [COORD_WIDTH-1:0] world_lo_z;
    logic signed [COORD_WIDTH-1:0] world_hi_x;
    logic signed [COORD_WIDTH-1:0] world_hi_y;
    logic signed [COORD_WIDTH-1:0] world_hi_z;

    modport source (output valid, world_lo_x, world_lo_y, world_lo_z,
                    world_hi_x, world_hi_y, world_hi_z, input ready);
    modport sink   (input valid, world_lo_x, world_lo_y, world_lo_z,
                    world_hi_x, world_hi_y, world_hi_z, output ready);
endinterface

@@ hdl/aabb_affine_transform.sv @@
// Top level of the box affine transform: local box in, world box out.
//
//   channel   dir  handshake      payload
//   box_in    in   valid/ready    lo_x lo_y lo_z hi_x hi_y hi_z
//   box_out   out  valid/ready    world_lo_x .. world_hi_z
//   cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// One box per cycle unless box_out stalls; the stages are product,
// per-term min/max, sum and round, widen, saturate. Each row's min and max
// come from the smaller and larger product of every coefficient.
// rst_n clears the valid bits and loads the identity matrix, zero shift
// and the default bias. A stall at box_out holds each stage in place; a
// stage with a free slot still takes the next transaction.
module aabb_affine_transform
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int CFG_DW      = (3 * COEF_WIDTH > COORD_WIDTH) ? 3 * COEF_WIDTH : COORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    aat_box_if.sink              box_in,
    aat_world_if.source          box_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int WW = COORD_WIDTH + COEF_WIDTH + 2;

    logic [3*COEF_WIDTH-1:0]       coefs [NUM_AXES];
    logic [COORD_WIDTH-1:0]        shifts [NUM_AXES];
    logic [BIAS_W-1:0]             bias;
    logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];
    logic signed [PW-1:0]          term_min [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          term_max [NUM_AXES][NUM_AXES];
    logic signed [WW-1:0]          wmin [NUM_AXES];
    logic signed [WW-1:0]          wmax [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] res_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] res_hi [NUM_AXES];
    logic                          mul_valid;
    logic                          sum_ready;
    logic                          sum_valid;
    logic                          widen_ready;

    // Unpack the input channel
    assign lo[0] = box_in.lo_x;
    assign lo[1] = box_in.lo_y;
    assign lo[2] = box_in.lo_z;
    assign hi[0] = box_in.hi_x;
    assign hi[1] = box_in.hi_y;
    assign hi[2] = box_in.hi_z;

    aat_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .CFG_DW      (CFG_DW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs),
        .shifts    (shifts),
        .bias      (bias)
    );

    aat_mul_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .PW          (PW)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box_in.valid),
        .in_ready  (box_in.ready),
        .lo        (lo),
        .hi        (hi),
        .coefs     (coefs),
        .out_valid (mul_valid),
        .out_ready (sum_ready),
        .term_min  (term_min),
        .term_max  (term_max)
    );

    aat_sum_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .PW          (PW),
        .WW          (WW)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (sum_ready),
        .term_min  (term_min),
        .term_max  (term_max),
        .shifts    (shifts),
        .out_valid (sum_valid),
        .out_ready (widen_ready),
        .wmin      (wmin),
        .wmax      (wmax)
    );

    aat_widen_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .WW          (WW)
    ) u_widen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (widen_ready),
        .wmin      (wmin),
        .wmax      (wmax),
        .bias      (bias),
        .out_valid (box_out.valid),
        .out_ready (box_out.ready),
        .res_lo    (res_lo),
        .res_hi    (res_hi)
    );

    // Pack the output channel
    assign box_out.world_lo_x = res_lo[0];
    assign box_out.world_lo_y = res_lo[1];
    assign box_out.world_lo_z = res_lo[2];
    assign box_out.world_hi_x = res_hi[0];
    assign box_out.world_hi_y = res_hi[1];
    assign box_out.world_hi_z = res_hi[2];

    // An empty output register lets every stage advance
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !box_out.valid |-> box_in.ready)
        else $error("input stalled while output register empty");

    // Min/max selection, widening and clamping keep each axis ordered
    a_axes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        box_out.valid |-> (box_out.world_lo_x <= box_out.world_hi_x) &&
                          (box_out.world_lo_y <= box_out.world_hi_y) &&
                          (box_out.world_lo_z <= box_out.world_hi_z))
        else $error("world box has lo above hi");

    // A result appears only after a transaction was valid at the sum stage output
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(box_out.valid) |-> $past(sum_valid, 2))
        else $error("result without a preceding transaction");

endmodule

@@ hdl/aat_cfg_regs.sv @@
// Configuration register file: matrix rows, translation and widening bias.
module aat_cfg_regs
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int CFG_DW      = 3 * COEF_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    output logic [3*COEF_WIDTH-1:0]  coefs [NUM_AXES],
    output logic [COORD_WIDTH-1:0]   shifts [NUM_AXES],
    output logic [BIAS_W-1:0]        bias
);

    localparam int RW = 3 * COEF_WIDTH;

    logic [RW-1:0]          row_reg [NUM_AXES];
    logic [COORD_WIDTH-1:0] shift_reg [NUM_AXES];
    logic [BIAS_W-1:0]      bias_reg;

    // Decode writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                row_reg[a]   <= RW'(ONE_Q16) << (a * COEF_WIDTH);
                shift_reg[a] <= '0;
            end
            bias_reg <= BIAS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_X:   row_reg[0]   <= cfg_data[RW-1:0];
                REG_ROW_Y:   row_reg[1]   <= cfg_data[RW-1:0];
                REG_ROW_Z:   row_reg[2]   <= cfg_data[RW-1:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                REG_BIAS:    bias_reg     <= cfg_data[BIAS_W-1:0];
                default:     ;
            endcase
        end
    end

    assign coefs  = row_reg;
    assign shifts = shift_reg;
    assign bias   = bias_reg;

endmodule

@@ hdl/aat_mul_stage.sv @@
// Products of every coefficient with both box bounds, then per-term min and max.
module aat_mul_stage
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int PW          = COORD_WIDTH + COEF_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] lo [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] hi [NUM_AXES],
    input  logic [3*COEF_WIDTH-1:0]       coefs [NUM_AXES],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [PW-1:0]          term_min [NUM_AXES][NUM_AXES],
    output logic signed [PW-1:0]          term_max [NUM_AXES][NUM_AXES]
);

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          ld1;
    logic                          ld2;
    logic signed [COEF_WIDTH-1:0]  coef [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          plo_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          phi_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          plo_reg [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          phi_reg [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          tmin_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          tmax_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          tmin_reg [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          tmax_reg [NUM_AXES][NUM_AXES];

    // Advance a stage when it is empty or its successor takes its item
    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // Multiply coefficient j of row a by bound j
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                coef[a][j]     = $signed(coefs[a][j*COEF_WIDTH +: COEF_WIDTH]);
                plo_next[a][j] = PW'(lo[j]) * PW'(coef[a][j]);
                phi_next[a][j] = PW'(hi[j]) * PW'(coef[a][j]);
            end
        end
    end

    // Pick the smaller and larger product of each term
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (plo_reg[a][j] < phi_reg[a][j])
                begin
                    tmin_next[a][j] = plo_reg[a][j];
                    tmax_next[a][j] = phi_reg[a][j];
                end
                else
                begin
                    tmin_next[a][j] = phi_reg[a][j];
                    tmax_next[a][j] = plo_reg[a][j];
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (ld2 && v1_reg)
        begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    assign out_valid = v2_reg;
    assign term_min  = tmin_reg;
    assign term_max  = tmax_reg;

endmodule

@@ hdl/aat_sum_stage.sv @@
// Sum the chosen terms, round once to Q16.16 and add the translation.
module aat_sum_stage
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int PW          = COORD_WIDTH + COEF_WIDTH,
    parameter int WW          = COORD_WIDTH + COEF_WIDTH + 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [PW-1:0]     term_min [NUM_AXES][NUM_AXES],
    input  logic signed [PW-1:0]     term_max [NUM_AXES][NUM_AXES],
    input  logic [COORD_WIDTH-1:0]   shifts [NUM_AXES],
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WW-1:0]     wmin [NUM_AXES],
    output logic signed [WW-1:0]     wmax [NUM_AXES]
);

    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

    logic                 v_reg;
    logic                 ld;
    logic signed [SW-1:0] smin;
    logic signed [SW-1:0] smax;
    logic signed [WW-1:0] wmin_next [NUM_AXES];
    logic signed [WW-1:0] wmax_next [NUM_AXES];
    logic signed [WW-1:0] wmin_reg [NUM_AXES];
    logic signed [WW-1:0] wmax_reg [NUM_AXES];

    assign ld       = !v_reg || out_ready;
    assign in_ready = ld;

    // Round half up, then translate
    always_comb
    begin
        smin = '0;
        smax = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            smin = SW'(term_min[a][0]) + SW'(term_min[a][1]) + SW'(term_min[a][2]) + HALF;
            smax = SW'(term_max[a][0]) + SW'(term_max[a][1]) + SW'(term_max[a][2]) + HALF;
            wmin_next[a] = WW'(smin >>> FRAC_BITS) + WW'($signed(shifts[a]));
            wmax_next[a] = WW'(smax >>> FRAC_BITS) + WW'($signed(shifts[a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (ld)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld && in_valid)
        begin
            wmin_reg <= wmin_next;
            wmax_reg <= wmax_next;
        end
    end

    assign out_valid = v_reg;
    assign wmin      = wmin_reg;
    assign wmax      = wmax_reg;

endmodule

@@ hdl/aat_widen_stage.sv @@
// Widen thin axes by the bias, then saturate into the output register.
module aat_widen_stage
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int WW          = COORD_WIDTH + COEF_WIDTH + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [WW-1:0]          wmin [NUM_AXES],
    input  logic signed [WW-1:0]          wmax [NUM_AXES],
    input  logic [BIAS_W-1:0]             bias,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] res_lo [NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] res_hi [NUM_AXES]
);

    localparam int XW = WW + 1;
    localparam logic signed [XW-1:0] SAT_MAX = {{(XW-COORD_WIDTH+1){1'b0}},
                                                {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_MIN = ~SAT_MAX;

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          ld1;
    logic                          ld2;
    logic signed [XW-1:0]          bias_s;
    logic signed [XW-1:0]          extent;
    logic signed [XW-1:0]          lo_next [NUM_AXES];
    logic signed [XW-1:0]          hi_next [NUM_AXES];
    logic signed [XW-1:0]          lo_reg [NUM_AXES];
    logic signed [XW-1:0]          hi_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] rlo_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] rhi_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] rlo_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] rhi_reg [NUM_AXES];

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;
    assign bias_s   = $signed({{(XW-BIAS_W){1'b0}}, bias});

    // Widen an axis whose extent is below the bias
    always_comb
    begin
        extent = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            extent = XW'(wmax[a]) - XW'(wmin[a]);
            if (extent < bias_s)
            begin
                lo_next[a] = XW'(wmin[a]) - bias_s;
                hi_next[a] = XW'(wmax[a]) + bias_s;
            end
            else
            begin
                lo_next[a] = XW'(wmin[a]);
                hi_next[a] = XW'(wmax[a]);
            end
        end
    end

    // Clamp to the coordinate range
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (lo_reg[a] > SAT_MAX)
                rlo_next[a] = SAT_MAX[COORD_WIDTH-1:0];
            else if (lo_reg[a] < SAT_MIN)
                rlo_next[a] = SAT_MIN[COORD_WIDTH-1:0];
            else
                rlo_next[a] = lo_reg[a][COORD_WIDTH-1:0];
            if (hi_reg[a] > SAT_MAX)
                rhi_next[a] = SAT_MAX[COORD_WIDTH-1:0];
            else if (hi_reg[a] < SAT_MIN)
                rhi_next[a] = SAT_MIN[COORD_WIDTH-1:0];
            else
                rhi_next[a] = hi_reg[a][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (ld2 && v1_reg)
        begin
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
        end
    end

    assign out_valid = v2_reg;
    assign res_lo    = rlo_reg;
    assign res_hi    = rhi_reg;

endmodule

@@ tb/sv/aabb_affine_transform_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the box affine transform: directed and random boxes, scoreboard.
module aabb_affine_transform_tb
    import aat_pkg::*;
;

    localparam int COORD_W        = COORD_WIDTH_DEF;
    localparam int COEF_W         = COEF_WIDTH_DEF;
    localparam int CFG_DW         = 3 * COEF_W;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_PRINTED    = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BOXES    = 205;

    // Index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } local_box_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_lo_x;
        logic signed [COORD_W-1:0] world_lo_y;
        logic signed [COORD_W-1:0] world_lo_z;
        logic signed [COORD_W-1:0] world_hi_x;
        logic signed [COORD_W-1:0] world_hi_y;
        logic signed [COORD_W-1:0] world_hi_z;
    } world_box_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    aat_box_if   #(.COORD_WIDTH(COORD_W)) box_in_if ();
    aat_world_if #(.COORD_WIDTH(COORD_W)) world_out_if ();

    // Shadow copy of the transform settings
    logic [CFG_DW-1:0]         mat_rows [NUM_AXES];
    logic signed [COORD_W-1:0] offset_q16 [NUM_AXES];
    logic [BIAS_W-1:0]         pad_q16;

    world_box_t pending_world_boxes [$];
    int         mismatch_count;
    int         idle_cycles;
    int         hold_off_cycles;
    bit         src_gaps_on;
    bit         sink_stalls_on;

    aabb_affine_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_in    (box_in_if),
        .box_out   (world_out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Clamp an exact coordinate to the output range
    function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return COORD_W'(v);
    endfunction

    // Map all eight corners, take per-axis min/max, widen thin axes, saturate
    function automatic world_box_t predict_world_box(local_box_t b);
        longint     lo_c [NUM_AXES];
        longint     hi_c [NUM_AXES];
        longint     corner [NUM_AXES];
        longint     wmin [NUM_AXES];
        longint     wmax [NUM_AXES];
        longint     exact;
        longint     mapped;
        world_box_t r;
        lo_c[0] = longint'(b.lo_x);
        lo_c[1] = longint'(b.lo_y);
        lo_c[2] = longint'(b.lo_z);
        hi_c[0] = longint'(b.hi_x);
        hi_c[1] = longint'(b.hi_y);
        hi_c[2] = longint'(b.hi_z);
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
                corner[j] = ((k >> j) & 1) ? hi_c[j] : lo_c[j];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                exact = 0;
                for (int j = 0; j < NUM_AXES; j++)
                    exact += longint'($signed(mat_rows[a][j*COEF_W +: COEF_W])) * corner[j];
                // round once to Q16.16, ties go up
                mapped = ((exact + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
                         + longint'(offset_q16[a]);
                if (k == 0 || mapped < wmin[a])
                    wmin[a] = mapped;
                if (k == 0 || mapped > wmax[a])
                    wmax[a] = mapped;
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (wmax[a] - wmin[a] < longint'(pad_q16))
            begin
                wmin[a] -= longint'(pad_q16);
                wmax[a] += longint'(pad_q16);
            end
        end
        r.world_lo_x = sat_coord(wmin[0]);
        r.world_lo_y = sat_coord(wmin[1]);
        r.world_lo_z = sat_coord(wmin[2]);
        r.world_hi_x = sat_coord(wmax[0]);
        r.world_hi_y = sat_coord(wmax[1]);
        r.world_hi_z = sat_coord(wmax[2]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [COORD_W-1:0] got_v,
                                   logic [COORD_W-1:0] want_v);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic check_field(string what, logic [COORD_W-1:0] got_v,
                               logic [COORD_W-1:0] want_v);
        if (got_v !== want_v)
            report_mismatch(what, got_v, want_v);
    endtask

    // Score results, predict accepted boxes, and watch for a hang
    always @(posedge clk)
    begin
        world_box_t got;
        world_box_t want;
        if (rst_n)
        begin
            if (world_out_if.valid && world_out_if.ready)
            begin
                got.world_lo_x = world_out_if.world_lo_x;
                got.world_lo_y = world_out_if.world_lo_y;
                got.world_lo_z = world_out_if.world_lo_z;
                got.world_hi_x = world_out_if.world_hi_x;
                got.world_hi_y = world_out_if.world_hi_y;
                got.world_hi_z = world_out_if.world_hi_z;
                if (pending_world_boxes.size() == 0)
                    report_mismatch("result with nothing pending", got.world_lo_x, '0);
                else
                begin
                    want = pending_world_boxes.pop_front();
                    check_field("world_lo_x", got.world_lo_x, want.world_lo_x);
                    check_field("world_lo_y", got.world_lo_y, want.world_lo_y);
                    check_field("world_lo_z", got.world_lo_z, want.world_lo_z);
                    check_field("world_hi_x", got.world_hi_x, want.world_hi_x);
                    check_field("world_hi_y", got.world_hi_y, want.world_hi_y);
                    check_field("world_hi_z", got.world_hi_z, want.world_hi_z);
                end
            end
            if (box_in_if.valid && box_in_if.ready)
                pending_world_boxes.push_back(predict_world_box('{
                    lo_x: box_in_if.lo_x, lo_y: box_in_if.lo_y, lo_z: box_in_if.lo_z,
                    hi_x: box_in_if.hi_x, hi_y: box_in_if.hi_y, hi_z: box_in_if.hi_z}));
            if ((box_in_if.valid && box_in_if.ready) ||
                (world_out_if.valid && world_out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive ready: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        world_out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                world_out_if.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_off_cycles > 0)
            begin
                world_out_if.ready <= 1'b0;
                stall_left = hold_off_cycles - 1;
                hold_off_cycles = 0;
            end
            else
            begin
                stall_left = sink_stalls_on ? pick_gap() : 0;
                if (stall_left > 0)
                begin
                    world_out_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                    world_out_if.ready <= 1'b1;
            end
        end
    end

    function automatic local_box_t make_box(
        logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] ly,
        logic signed [COORD_W-1:0] lz, logic signed [COORD_W-1:0] hx,
        logic signed [COORD_W-1:0] hy, logic signed [COORD_W-1:0] hz);
        return '{lo_x: lx, lo_y: ly, lo_z: lz, hi_x: hx, hi_y: hy, hi_z: hz};
    endfunction

    // Offer one box at a falling edge and hold it until accepted
    task automatic send_box(local_box_t b);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            box_in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_in_if.valid <= 1'b1;
        box_in_if.lo_x  <= b.lo_x;
        box_in_if.lo_y  <= b.lo_y;
        box_in_if.lo_z  <= b.lo_z;
        box_in_if.hi_x  <= b.hi_x;
        box_in_if.hi_y  <= b.hi_y;
        box_in_if.hi_z  <= b.hi_z;
        @(posedge clk);
        while (!box_in_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait for every pending result
    task automatic wait_idle();
        box_in_if.valid <= 1'b0;
        while (pending_world_boxes.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx) inside
            REG_ROW_X, REG_ROW_Y, REG_ROW_Z:
                mat_rows[idx] = data;
            REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
                offset_q16[int'(idx - REG_SHIFT_X)] = data[COORD_W-1:0];
            REG_BIAS:
                pad_q16 = data[BIAS_W-1:0];
            default:
                ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_transform(logic [CFG_DW-1:0] rx, logic [CFG_DW-1:0] ry,
                                 logic [CFG_DW-1:0] rz, logic signed [COORD_W-1:0] sx,
                                 logic signed [COORD_W-1:0] sy,
                                 logic signed [COORD_W-1:0] sz, logic [BIAS_W-1:0] bias);
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_SHIFT_X, CFG_DW'(sx));
        write_reg(REG_SHIFT_Y, CFG_DW'(sy));
        write_reg(REG_SHIFT_Z, CFG_DW'(sz));
        write_reg(REG_BIAS, CFG_DW'(bias));
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        int v;
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return COEF_W'($urandom);
            default:
            begin
                // within +/-2.0
                v = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                return COEF_W'(v);
            end
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rand_row();
        logic [CFG_DW-1:0] row;
        if ($urandom_range(0, 7) == 0)
            row = CFG_DW'({$urandom, $urandom});
        else
            for (int j = 0; j < NUM_AXES; j++)
                row[j*COEF_W +: COEF_W] = rand_coef();
        return row;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return COORD_W'($urandom);
            default:
            begin
                // within +/-256.0
                v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                return COORD_W'(v);
            end
        endcase
    endfunction

    function automatic logic [BIAS_W-1:0] rand_bias();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return BIAS_RESET;
            default: return BIAS_W'($urandom);
        endcase
    endfunction

    // Mostly ordered boxes, some points and slivers, a few inverted
    function automatic local_box_t rand_box();
        logic signed [COORD_W-1:0] a [NUM_AXES];
        logic signed [COORD_W-1:0] c [NUM_AXES];
        logic signed [COORD_W-1:0] t;
        int shape;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a[i]  = rand_coord();
            shape = $urandom_range(0, 19);
            if (shape < 2)
                c[i] = a[i];
            else if (shape < 5)
                c[i] = a[i] + COORD_W'($urandom_range(0, 1000));
            else
                c[i] = rand_coord();
            if ($urandom_range(0, 9) != 0 && a[i] > c[i])
            begin
                t    = a[i];
                a[i] = c[i];
                c[i] = t;
            end
        end
        return make_box(a[0], a[1], a[2], c[0], c[1], c[2]);
    endfunction

    task automatic randomize_transform();
        set_transform(rand_row(), rand_row(), rand_row(), rand_coord(), rand_coord(),
                      rand_coord(), rand_bias());
    endtask

    // Identity after reset: widening of flat boxes, saturation, inverted box
    task automatic test_identity_boxes();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(32'h0005_0000, 32'hFFFD_0000, 32'h0001_0000,
                          32'hFFFD_0000, 32'h0005_0000, 32'hFFFF_0000));
        // extent equal to the bias stays, one below it widens
        send_box(make_box(0, 0, 0, 655, 654, 656));
        wait_idle();
    endtask

    // Extreme coefficients, shifts and bias; rounding ties
    task automatic test_matrix_extremes();
        set_transform({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}},
                      COORD_MAX, COORD_MAX, COORD_MAX, '1);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        wait_idle();
        set_transform({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}},
                      COORD_MIN, COORD_MIN, COORD_MIN, '0);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                          32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        wait_idle();
        // one LSB coefficients expose the half-way rounding
        set_transform({20'h00000, 20'h00000, 20'h00001},
                      {20'h00000, 20'hFFFFF, 20'h00000},
                      {COEF_MAX, COEF_MIN, 20'h00001}, 0, 0, 0, '0);
        send_box(make_box(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                          32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        send_box(make_box(32'hFFFF_8000, 32'h0001_8000, 32'hFFFF_8000,
                          32'hFFFF_8000, 32'h0001_8000, 32'hFFFF_8000));
        send_box(make_box(32'hFFFE_8000, 32'hFFFE_8000, 32'hFFFE_8000,
                          32'h0000_8000, 32'h0003_8000, 32'h0000_8000));
        wait_idle();
    endtask

    // A write past the last register leaves the transform alone
    task automatic test_unused_index();
        write_reg(REG_NONE, '1);
        send_box(make_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0004_0000, 32'h0005_0000, 32'h0006_0000));
        wait_idle();
    endtask

    // Hold the output off long enough that the input stalls
    task automatic test_backpressure();
        randomize_transform();
        src_gaps_on = 1'b0;
        hold_off_cycles = 300;
        repeat (40)
            send_box(rand_box());
        wait_idle();
        src_gaps_on = 1'b1;
    endtask

    // Random settings per phase, random boxes, idling on or off per side
    task automatic test_random_boxes();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_transform();
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_BOXES)
                send_box(rand_box());
            wait_idle();
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_ROW_X;
        cfg_data        = '0;
        box_in_if.valid = 1'b0;
        box_in_if.lo_x  = '0;
        box_in_if.lo_y  = '0;
        box_in_if.lo_z  = '0;
        box_in_if.hi_x  = '0;
        box_in_if.hi_y  = '0;
        box_in_if.hi_z  = '0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        hold_off_cycles = 0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        // reset state of the transform: identity, no shift, default bias
        mat_rows[0]   = CFG_DW'(ONE_Q16);
        mat_rows[1]   = CFG_DW'(ONE_Q16) << COEF_W;
        mat_rows[2]   = CFG_DW'(ONE_Q16) << (2 * COEF_W);
        offset_q16[0] = '0;
        offset_q16[1] = '0;
        offset_q16[2] = '0;
        pad_q16       = BIAS_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_identity_boxes();
        test_matrix_extremes();
        test_unused_index();
        test_backpressure();
        test_random_boxes();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/aat_pkg.sv
hdl/aat_if.sv
hdl/aat_cfg_regs.sv
hdl/aat_mul_stage.sv
hdl/aat_sum_stage.sv
hdl/aat_widen_stage.sv
hdl/aabb_affine_transform.sv
tb/sv/aabb_affine_transform_tb.sv
